// ===== design/mfcc_pkg.sv =====
// mfcc_pkg: shared types and constants of the measurement frame crc checker
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package mfcc_pkg;

  localparam int unsigned FrameBytes = 9;
  localparam int unsigned IndexW     = 4;
  localparam int unsigned WordsPerFrame = 3;

  typedef logic [7:0]        byte_t;
  typedef logic [15:0]       word_t;
  typedef logic [IndexW-1:0] index_t;
  typedef logic [1:0]        status_t;
  typedef logic [WordsPerFrame-1:0] flags_t;

  localparam byte_t  CrcInitReset = 8'hFF;
  localparam byte_t  CrcPolyReset = 8'h31;
  localparam index_t LastIndex    = index_t'(FrameBytes - 1);

  // configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_CRC_INIT = 1'b0;
  localparam cfg_index_t CFG_CRC_POLY = 1'b1;

  // status codes
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_HUMID_BAD = 2'd1;
  localparam status_t STATUS_TEMP_BAD  = 2'd2;
  localparam status_t STATUS_CO2_BAD   = 2'd3;

  // which word and which byte of the word a frame position holds
  typedef enum logic [1:0] {
    WORD_CO2,
    WORD_TEMP,
    WORD_HUMID
  } word_sel_t;

  typedef enum logic [1:0] {
    SUB_HIGH,
    SUB_LOW,
    SUB_CRC
  } sub_sel_t;

  typedef struct packed {
    word_sel_t word;
    sub_sel_t  sub;
  } slot_t;

  function automatic slot_t slot_of(input index_t pos);
    slot_t s;
    unique case (pos)
      4'd0:    s = '{WORD_CO2,   SUB_HIGH};
      4'd1:    s = '{WORD_CO2,   SUB_LOW};
      4'd2:    s = '{WORD_CO2,   SUB_CRC};
      4'd3:    s = '{WORD_TEMP,  SUB_HIGH};
      4'd4:    s = '{WORD_TEMP,  SUB_LOW};
      4'd5:    s = '{WORD_TEMP,  SUB_CRC};
      4'd6:    s = '{WORD_HUMID, SUB_HIGH};
      4'd7:    s = '{WORD_HUMID, SUB_LOW};
      4'd8:    s = '{WORD_HUMID, SUB_CRC};
      default: s = '{WORD_CO2,   SUB_HIGH};
    endcase
    return s;
  endfunction

  typedef struct packed {
    word_t   co2_word;
    word_t   temp_word;
    word_t   humid_word;
    status_t status;
  } result_t;

endpackage

// ===== design/mfcc_ifs.sv =====
// mfcc_in_if / mfcc_out_if: valid/ready channels of the frame checker
// depends on mfcc_pkg for payload types
`timescale 1ns / 1ps

interface mfcc_in_if;
  logic            valid;
  logic            ready;
  mfcc_pkg::byte_t data_byte;
  logic            frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface mfcc_out_if;
  logic              valid;
  logic              ready;
  mfcc_pkg::word_t   co2_word;
  mfcc_pkg::word_t   temp_word;
  mfcc_pkg::word_t   humid_word;
  mfcc_pkg::status_t status;

  modport source (output valid, output co2_word, output temp_word, output humid_word,
                  output status, input ready);
  modport sink   (input valid, input co2_word, input temp_word, input humid_word,
                  input status, output ready);
endinterface

// ===== design/mfcc_crc8.sv =====
// mfcc_crc8: one byte through an msb-first crc-8 with programmable polynomial
// depends on mfcc_pkg
`timescale 1ns / 1ps

module mfcc_crc8 (
  input  mfcc_pkg::byte_t seed,
  input  mfcc_pkg::byte_t data,
  input  mfcc_pkg::byte_t poly,
  output mfcc_pkg::byte_t crc
);

  always_comb begin
    mfcc_pkg::byte_t r;
    r = seed ^ data;
    for (int b = 0; b < 8; b++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ poly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    crc = r;
  end

endmodule

// ===== design/mfcc_frame.sv =====
// mfcc_frame: byte position tracking, word capture and crc checking of one frame
// depends on mfcc_pkg and mfcc_crc8
`timescale 1ns / 1ps

module mfcc_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  mfcc_pkg::byte_t   data_byte,
  input  logic              frame_start,
  input  mfcc_pkg::byte_t   crc_init,
  input  mfcc_pkg::byte_t   crc_poly,
  output logic              res_valid,
  output mfcc_pkg::result_t res
);

  mfcc_pkg::index_t byte_index;
  mfcc_pkg::byte_t  running_crc;
  mfcc_pkg::byte_t  word_high_byte;
  mfcc_pkg::word_t  co2_hold;
  mfcc_pkg::word_t  temp_hold;
  mfcc_pkg::word_t  humid_hold;
  mfcc_pkg::flags_t crc_fail_flags;

  mfcc_pkg::index_t pos;
  mfcc_pkg::slot_t  slot;
  mfcc_pkg::byte_t  crc_seed;
  mfcc_pkg::byte_t  crc_out;
  mfcc_pkg::word_t  word_in;
  mfcc_pkg::flags_t flags_base;
  mfcc_pkg::flags_t crc_fail_flags_next;

  // stray count values restart the frame
  always_comb begin
    if (frame_start || byte_index > mfcc_pkg::LastIndex) begin
      pos = '0;
    end else begin
      pos = byte_index;
    end
  end

  assign slot     = mfcc_pkg::slot_of(pos);
  assign crc_seed = (slot.sub == mfcc_pkg::SUB_HIGH) ? crc_init : running_crc;
  assign word_in  = {word_high_byte, data_byte};

  mfcc_crc8 u_crc (
    .seed (crc_seed),
    .data (data_byte),
    .poly (crc_poly),
    .crc  (crc_out)
  );

  always_comb begin
    flags_base = (pos == '0) ? '0 : crc_fail_flags;
    crc_fail_flags_next = flags_base;
    if (slot.sub == mfcc_pkg::SUB_CRC && data_byte != running_crc) begin
      crc_fail_flags_next[slot.word] = 1'b1;
    end
  end

  always_comb begin
    res_valid      = en && (pos == mfcc_pkg::LastIndex);
    res.co2_word   = co2_hold;
    res.temp_word  = temp_hold;
    res.humid_word = humid_hold;
    priority if (crc_fail_flags_next[mfcc_pkg::WORD_HUMID]) begin
      res.status = mfcc_pkg::STATUS_HUMID_BAD;
    end else if (crc_fail_flags_next[mfcc_pkg::WORD_TEMP]) begin
      res.status = mfcc_pkg::STATUS_TEMP_BAD;
    end else if (crc_fail_flags_next[mfcc_pkg::WORD_CO2]) begin
      res.status = mfcc_pkg::STATUS_CO2_BAD;
    end else begin
      res.status = mfcc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index     <= '0;
      running_crc    <= mfcc_pkg::CrcInitReset;
      word_high_byte <= '0;
      co2_hold       <= '0;
      temp_hold      <= '0;
      humid_hold     <= '0;
      crc_fail_flags <= '0;
    end else if (en) begin
      crc_fail_flags <= crc_fail_flags_next;
      byte_index     <= (pos == mfcc_pkg::LastIndex) ? '0 : pos + 1'b1;
      unique case (slot.sub)
        mfcc_pkg::SUB_HIGH: begin
          word_high_byte <= data_byte;
          running_crc    <= crc_out;
        end
        mfcc_pkg::SUB_LOW: begin
          running_crc <= crc_out;
          unique case (slot.word)
            mfcc_pkg::WORD_CO2:  co2_hold   <= word_in;
            mfcc_pkg::WORD_TEMP: temp_hold  <= word_in;
            default:             humid_hold <= word_in;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= mfcc_pkg::LastIndex)
    else $error("byte index out of frame range");

  a_result_wraps: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> byte_index == '0)
    else $error("byte index did not wrap after last byte");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(byte_index) && $stable(crc_fail_flags) && $stable(running_crc))
    else $error("frame state moved without an item");

endmodule

// ===== design/measurement_frame_crc_checker_unit.sv =====
// measurement_frame_crc_checker_unit: top level of the frame crc checker
// depends on mfcc_pkg, mfcc_ifs (mfcc_in_if, mfcc_out_if) and mfcc_frame
`timescale 1ns / 1ps

// channel   dir  payload                                        handshake
// in_ch     in   data_byte[7:0], frame_start                    valid/ready
// out_ch    out  co2_word, temp_word, humid_word [15:0], status  valid/ready
// cfg       in   cfg_index[0], cfg_data[7:0]                    cfg_we, no wait
//
// one byte per cycle sustained while out_ch is not stalled; each byte passes the input register
// and a frame's result shows in the output register in the cycle after the frame logic takes its ninth byte
// rst is synchronous: byte count 0, crc_init 0xff, crc_poly 0x31, both sides empty
// a stalled result freezes the frame logic; the input register still takes one
// more item if it is empty, then ready drops until out_ch drains

module measurement_frame_crc_checker_unit (
  input  logic                 clk,
  input  logic                 rst,
  mfcc_in_if.sink              in_ch,
  mfcc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  mfcc_pkg::cfg_index_t cfg_index,
  input  mfcc_pkg::byte_t      cfg_data
);

  mfcc_pkg::byte_t   crc_init;
  mfcc_pkg::byte_t   crc_poly;

  logic              in_valid_q;
  mfcc_pkg::byte_t   in_byte_q;
  logic              in_start_q;

  logic              advance;
  logic              frame_en;
  logic              res_valid;
  mfcc_pkg::result_t res;

  logic              out_valid;
  mfcc_pkg::result_t out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_init <= mfcc_pkg::CrcInitReset;
      crc_poly <= mfcc_pkg::CrcPolyReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfcc_pkg::CFG_CRC_INIT: crc_init <= cfg_data;
        default:                crc_poly <= cfg_data;
      endcase
    end
  end

  // the frame stage moves when it holds an item and the output slot can take a result
  assign advance     = !out_valid || out_ch.ready;
  assign frame_en    = in_valid_q && advance;
  assign in_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      in_byte_q  <= in_ch.data_byte;
      in_start_q <= in_ch.frame_start;
    end
  end

  mfcc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .en          (frame_en),
    .data_byte   (in_byte_q),
    .frame_start (in_start_q),
    .crc_init    (crc_init),
    .crc_poly    (crc_poly),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.co2_word   = out_q.co2_word;
  assign out_ch.temp_word  = out_q.temp_word;
  assign out_ch.humid_word = out_q.humid_word;
  assign out_ch.status     = out_q.status;

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_start_q))
    else $error("input register lost an item during a stall");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(frame_en))
    else $error("result appeared without a processed item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> frame_en && advance)
    else $error("result produced while output slot was full");

endmodule

// ===== bench/measurement_frame_crc_checker_unit_tb.sv =====
// measurement_frame_crc_checker_unit_tb: self-checking bench for the frame crc checker
// feeds full and partial frames with good and bad crc bytes under several crc settings, predicts
// each frame result and compares it field by field; needs mfcc_pkg, mfcc_ifs and the rtl
`timescale 1ns / 1ps

module measurement_frame_crc_checker_unit_tb;

  localparam int unsigned CycleLimit   = 200000;
  localparam int          TotalItems   = 770;
  localparam int          QuietFrom    = 620;
  localparam int          HoldAt       = 300;
  localparam int          LongHold     = 40;
  localparam int          SettleCycles = 6;
  localparam int          PhaseUnits   = 10;

  // tracks the frame position, crc and held words, and keeps the frame results still due
  class frame_tracker;
    mfcc_pkg::byte_t   init_val;
    mfcc_pkg::byte_t   poly_val;
    mfcc_pkg::index_t  pos_q;
    mfcc_pkg::byte_t   crc_acc;
    mfcc_pkg::byte_t   high_q;
    mfcc_pkg::word_t   co2_q;
    mfcc_pkg::word_t   temp_q;
    mfcc_pkg::word_t   humid_q;
    mfcc_pkg::flags_t  bad_q;
    mfcc_pkg::result_t frames_due[$];
    int                errors;

    function new();
      init_val = mfcc_pkg::CrcInitReset;
      poly_val = mfcc_pkg::CrcPolyReset;
      pos_q    = '0;
      crc_acc  = mfcc_pkg::CrcInitReset;
      high_q   = '0;
      co2_q    = '0;
      temp_q   = '0;
      humid_q  = '0;
      bad_q    = '0;
      errors   = 0;
    endfunction

    function void set_reg(mfcc_pkg::cfg_index_t idx, mfcc_pkg::byte_t v);
      if (idx == mfcc_pkg::CFG_CRC_INIT) begin
        init_val = v;
      end else begin
        poly_val = v;
      end
    endfunction

    // msb-first crc-8, no final xor
    function mfcc_pkg::byte_t crc_feed(mfcc_pkg::byte_t c, mfcc_pkg::byte_t b);
      mfcc_pkg::byte_t r;
      r = c ^ b;
      for (int i = 0; i < 8; i++) begin
        r = r[7] ? ((r << 1) ^ poly_val) : (r << 1);
      end
      return r;
    endfunction

    function bit at_boundary();
      return pos_q == '0;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function void note_byte(mfcc_pkg::byte_t b, logic start);
      mfcc_pkg::index_t    p;
      mfcc_pkg::word_sel_t w;
      mfcc_pkg::sub_sel_t  slot_part;
      mfcc_pkg::result_t   r;
      p = start ? mfcc_pkg::index_t'(0) : pos_q;
      if (p > mfcc_pkg::LastIndex) p = '0;
      w         = mfcc_pkg::word_sel_t'(2'(p / 4'd3));
      slot_part = mfcc_pkg::sub_sel_t'(2'(p % 4'd3));
      if (p == '0) bad_q = '0;
      case (slot_part)
        mfcc_pkg::SUB_HIGH: begin
          high_q  = b;
          crc_acc = crc_feed(init_val, b);
        end
        mfcc_pkg::SUB_LOW: begin
          crc_acc = crc_feed(crc_acc, b);
          case (w)
            mfcc_pkg::WORD_CO2:  co2_q   = {high_q, b};
            mfcc_pkg::WORD_TEMP: temp_q  = {high_q, b};
            default:             humid_q = {high_q, b};
          endcase
        end
        default: begin
          if (b != crc_acc) bad_q[w] = 1'b1;
        end
      endcase
      if (p == mfcc_pkg::LastIndex) begin
        r.co2_word   = co2_q;
        r.temp_word  = temp_q;
        r.humid_word = humid_q;
        if (bad_q[mfcc_pkg::WORD_HUMID]) begin
          r.status = mfcc_pkg::STATUS_HUMID_BAD;
        end else if (bad_q[mfcc_pkg::WORD_TEMP]) begin
          r.status = mfcc_pkg::STATUS_TEMP_BAD;
        end else if (bad_q[mfcc_pkg::WORD_CO2]) begin
          r.status = mfcc_pkg::STATUS_CO2_BAD;
        end else begin
          r.status = mfcc_pkg::STATUS_OK;
        end
        frames_due.push_back(r);
        pos_q = '0;
      end else begin
        pos_q = p + 1'b1;
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_frame(mfcc_pkg::result_t got);
      mfcc_pkg::result_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("unexpected frame result co2=%h temp=%h humid=%h status=%0d",
                         got.co2_word, got.temp_word, got.humid_word, got.status));
        return;
      end
      want = frames_due.pop_front();
      if (got.co2_word != want.co2_word)
        report($sformatf("co2_word got %h want %h", got.co2_word, want.co2_word));
      if (got.temp_word != want.temp_word)
        report($sformatf("temp_word got %h want %h", got.temp_word, want.temp_word));
      if (got.humid_word != want.humid_word)
        report($sformatf("humid_word got %h want %h", got.humid_word, want.humid_word));
      if (got.status != want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  mfcc_pkg::cfg_index_t cfg_index;
  mfcc_pkg::byte_t      cfg_data;

  mfcc_in_if  in_ch ();
  mfcc_out_if out_ch ();

  frame_tracker      sb = new();
  mfcc_pkg::result_t got;
  int unsigned       cycle_count = 0;
  int                sent_items = 0;
  bit                idling = 1'b1;
  bit                long_hold_req = 1'b0;

  measurement_frame_crc_checker_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("measurement_frame_crc_checker_unit verification failed");
      $finish;
    end
  end

  // check results before noting inputs so a new expectation never covers a stray result
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.co2_word   = out_ch.co2_word;
        got.temp_word  = out_ch.temp_word;
        got.humid_word = out_ch.humid_word;
        got.status     = out_ch.status;
        sb.check_frame(got);
      end
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.frame_start);
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input mfcc_pkg::byte_t b, input logic start);
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.frame_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  // sends the first n bytes of a frame; crc bytes flagged in bad are corrupted
  task automatic send_frame(input mfcc_pkg::word_t co2, input mfcc_pkg::word_t temp,
                            input mfcc_pkg::word_t humid, input mfcc_pkg::flags_t bad,
                            input logic start, input int n);
    mfcc_pkg::byte_t seq[9];
    mfcc_pkg::word_t w[3];
    mfcc_pkg::byte_t c;
    w[0] = co2;
    w[1] = temp;
    w[2] = humid;
    for (int i = 0; i < 3; i++) begin
      c = sb.crc_feed(sb.crc_feed(sb.init_val, w[i][15:8]), w[i][7:0]);
      if (bad[i]) c ^= mfcc_pkg::byte_t'($urandom_range(1, 255));
      seq[3*i]   = w[i][15:8];
      seq[3*i+1] = w[i][7:0];
      seq[3*i+2] = c;
    end
    for (int i = 0; i < n; i++) send_byte(seq[i], (i == 0) ? start : 1'b0);
  endtask

  // stop offering and wait until every due frame result has come out
  task automatic drain(input int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input mfcc_pkg::cfg_index_t idx, input mfcc_pkg::byte_t v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic mfcc_pkg::word_t any_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return mfcc_pkg::word_t'($urandom);
    endcase
  endfunction

  initial begin
    mfcc_pkg::byte_t  init_plan[4];
    mfcc_pkg::byte_t  poly_plan[4];
    int               phase;
    int               units;
    int               kind;
    int               n;
    bit               hold_done;
    logic             start;
    mfcc_pkg::flags_t bad;

    init_plan = '{8'h00, 8'hFF, 8'h00, 8'hA5};
    poly_plan = '{8'h00, 8'hFF, 8'h07, 8'h31};
    phase     = 0;
    units     = 0;
    hold_done = 1'b0;

    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.frame_start = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = mfcc_pkg::CFG_CRC_INIT;
    cfg_data          = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // count runs from reset without a frame_start; extreme words, good crcs
    send_frame(16'h0000, 16'hFFFF, 16'h8000, 3'b000, 1'b0, 9);
    // partial frame dropped by a frame_start
    send_frame(16'h1234, 16'h00FF, 16'hFF00, 3'b000, 1'b1, 3);
    // every crc wrong: humidity wins
    send_frame(16'hFF00, 16'h7FFF, 16'h0001, 3'b111, 1'b1, 9);

    while (sent_items < TotalItems) begin
      if (units == PhaseUnits) begin
        drain(SettleCycles);
        if (phase < 4) begin
          write_reg(mfcc_pkg::CFG_CRC_INIT, init_plan[phase]);
          write_reg(mfcc_pkg::CFG_CRC_POLY, poly_plan[phase]);
        end else if ($urandom_range(0, 1) == 0) begin
          write_reg(mfcc_pkg::CFG_CRC_POLY, mfcc_pkg::byte_t'($urandom));
        end else begin
          write_reg(mfcc_pkg::CFG_CRC_INIT, mfcc_pkg::byte_t'($urandom));
          write_reg(mfcc_pkg::CFG_CRC_POLY, mfcc_pkg::byte_t'($urandom));
        end
        phase++;
        units = 0;
      end
      if (!hold_done && sent_items > HoldAt) begin
        // results back up while frames keep coming
        idling        = 1'b0;
        long_hold_req = 1'b1;
        repeat (3) send_frame(any_word(), any_word(), any_word(), 3'b000, 1'b1, 9);
        idling    = 1'b1;
        hold_done = 1'b1;
      end
      if (sent_items > QuietFrom) idling = 1'b0;
      kind  = $urandom_range(0, 19);
      start = sb.at_boundary() ? logic'($urandom_range(0, 3) != 0) : 1'b1;
      bad   = {$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
               $urandom_range(0, 3) == 0};
      if (kind < 14) begin
        send_frame(any_word(), any_word(), any_word(), bad, start, 9);
      end else if (kind < 17) begin
        send_frame(any_word(), any_word(), any_word(), bad, start, $urandom_range(1, 8));
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(mfcc_pkg::byte_t'($urandom), logic'($urandom_range(0, 7) == 0));
      end
      units++;
    end

    drain(SettleCycles + 2);
    if (sb.errors == 0) begin
      $display("measurement_frame_crc_checker_unit verification clean");
    end else begin
      $display("measurement_frame_crc_checker_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mfcc_pkg.sv
design/mfcc_ifs.sv
design/mfcc_crc8.sv
design/mfcc_frame.sv
design/measurement_frame_crc_checker_unit.sv
bench/measurement_frame_crc_checker_unit_tb.sv
